// ===== design/rtccal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rtccal_pkg;

   // Item function codes.
   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_WAIT = 2'd1;
   localparam logic [1:0] FUNC_SET  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SAMPLES = 2'd0;
   localparam logic [1:0] CSR_SINGLE  = 2'd1;
   localparam logic [1:0] CSR_NO_BUS  = 2'd2;

   localparam logic [5:0] SAMPLES_RESET = 6'd12;

   // Calendar limits.
   localparam logic [6:0] SEC_LIMIT    = 7'd60;
   localparam logic [6:0] MIN_LIMIT    = 7'd60;
   localparam logic [5:0] HOUR_LIMIT   = 6'd24;
   localparam logic [4:0] MONTH_LAST   = 5'd12;
   localparam logic [6:0] YEAR_END     = 7'd50;
   localparam logic [5:0] YEAR_FIRST   = 6'd11;
   localparam logic [3:0] MONTH_FEB    = 4'd2;
   localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

   // Shift-subtract remainder unit.
   localparam logic [2:0] REM_STEPS   = 3'd6;
   localparam logic [5:0] SEC_DIVISOR = 6'd3;

   // Days in each month; codes outside one to twelve count as 31, zero as 0.
   localparam logic [4:0] MONTH_DAYS [16] = '{
      5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
   };

   // Minute divisor for each samples-per-hour value: sixty divided by the
   // value, sixty for zero and one above sixty.
   localparam logic [5:0] DIV_TABLE [64] = '{
      6'd60, 6'd60, 6'd30, 6'd20, 6'd15, 6'd12, 6'd10, 6'd8,
      6'd7,  6'd6,  6'd6,  6'd5,  6'd5,  6'd4,  6'd4,  6'd4,
      6'd3,  6'd3,  6'd3,  6'd3,  6'd3,  6'd2,  6'd2,  6'd2,
      6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd1,
      6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,
      6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,
      6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,
      6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIN_START,
      ST_MIN_WAIT,
      ST_SEC_START,
      ST_SEC_WAIT,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [5:0] samples_per_hour;
      logic       single_mode;
      logic       no_bus_mode;
   } cfg_type;

   typedef struct packed {
      logic second;
      logic minute;
   } roll_type;

   typedef struct packed {
      logic idle;
      logic accept;
      logic rem_start;
      logic sel_minute;
      logic apply_read;
      logic apply_update;
      logic load_rsp;
   } ctrl_type;

   typedef struct packed {
      logic done;
      logic zero;
   } rem_type;

   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [5:0]  year;
      logic [2:0]  keys;
      logic        key_flag;
      logic        read_flag;
      logic        update_flag;
      logic        led;
      logic [15:0] wait_left;
   } cal_type;

endpackage

`default_nettype wire

// ===== design/rtccal_rem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module rtccal_rem (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [5:0]          dividend,
   input  wire logic [5:0]          divisor,
   output rtccal_pkg::rem_type      status
);

   logic [2:0] cnt_ff, cnt_in;
   logic       done_ff, done_in;
   logic [5:0] q_ff, q_in;
   logic [5:0] d_ff, d_in;
   logic [5:0] r_ff, r_in;
   logic [6:0] trial;
   logic [6:0] diff;

   assign trial = {r_ff, q_ff[5]};
   assign diff  = trial - {1'b0, d_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      done_in = (cnt_ff == 3'd1) && !start;
      if (start) begin
         cnt_in = rtccal_pkg::REM_STEPS;
         q_in   = dividend;
         d_in   = divisor;
         r_in   = 6'd0;
      end else if (cnt_ff != 3'd0) begin
         // The partial remainder stays below the divisor, so six bits hold it.
         r_in   = (trial >= {1'b0, d_ff}) ? diff[5:0] : trial[5:0];
         q_in   = {q_ff[4:0], 1'b0};
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      d_ff <= d_in;
      r_ff <= r_in;
   end

   assign status.done = done_ff;
   assign status.zero = (r_ff == 6'd0);

endmodule

`default_nettype wire

// ===== design/rtccal_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtccal_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 rsp_free,
   input  rtccal_pkg::roll_type      roll,
   input  rtccal_pkg::rem_type       rem,
   output rtccal_pkg::ctrl_type      ctrl
);

   rtccal_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtccal_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (roll.minute) begin
                  state_in = rtccal_pkg::ST_MIN_START;
               end else if (roll.second) begin
                  state_in = rtccal_pkg::ST_SEC_START;
               end else begin
                  state_in = rtccal_pkg::ST_DONE;
               end
            end
         end
         rtccal_pkg::ST_MIN_START: state_in = rtccal_pkg::ST_MIN_WAIT;
         rtccal_pkg::ST_MIN_WAIT: begin
            if (rem.done) begin
               state_in = rtccal_pkg::ST_SEC_START;
            end
         end
         rtccal_pkg::ST_SEC_START: state_in = rtccal_pkg::ST_SEC_WAIT;
         rtccal_pkg::ST_SEC_WAIT: begin
            if (rem.done) begin
               state_in = rtccal_pkg::ST_DONE;
            end
         end
         rtccal_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = rtccal_pkg::ST_IDLE;
            end
         end
         default: state_in = rtccal_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl.idle         = (state_ff == rtccal_pkg::ST_IDLE);
      ctrl.accept       = (state_ff == rtccal_pkg::ST_IDLE) && req_valid;
      ctrl.rem_start    = (state_ff == rtccal_pkg::ST_MIN_START) ||
                          (state_ff == rtccal_pkg::ST_SEC_START);
      ctrl.sel_minute   = (state_ff == rtccal_pkg::ST_MIN_START);
      ctrl.apply_read   = (state_ff == rtccal_pkg::ST_MIN_WAIT) && rem.done;
      ctrl.apply_update = (state_ff == rtccal_pkg::ST_SEC_WAIT) && rem.done;
      ctrl.load_rsp     = (state_ff == rtccal_pkg::ST_DONE) && rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtccal_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/rtccal_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtccal_core #(
   parameter int TICKS_PER_SECOND = 40,
   parameter int DEBOUNCE_HOLD    = 20,
   parameter int LED_OFF_TICK     = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  rtccal_pkg::ctrl_type     ctrl,
   input  rtccal_pkg::cfg_type      cfg,
   input  rtccal_pkg::rem_type      rem,
   input  wire logic [1:0]          req_func,
   input  wire logic [2:0]          req_key_pins,
   input  wire logic [15:0]         req_wait_load,
   input  wire logic [5:0]          req_set_second,
   input  wire logic [5:0]          req_set_minute,
   input  wire logic [4:0]          req_set_hour,
   input  wire logic [4:0]          req_set_day,
   input  wire logic [3:0]          req_set_month,
   input  wire logic [5:0]          req_set_year,
   input  wire logic                req_clear_read,
   input  wire logic                req_clear_update,
   input  wire logic                req_clear_key,
   output rtccal_pkg::roll_type     roll,
   output rtccal_pkg::cal_type      cal
);

   logic [5:0]  tick_ff, tick_in;
   logic [4:0]  debounce_ff, debounce_in;
   logic        leap_ff, leap_in;
   rtccal_pkg::cal_type cal_ff, cal_in;

   logic [6:0]  tick_sum;
   logic [6:0]  sec_sum;
   logic [6:0]  min_sum;
   logic [5:0]  hour_sum;
   logic [5:0]  day_sum;
   logic [4:0]  month_sum;
   logic [6:0]  year_sum;
   logic [5:0]  year_next;
   logic [4:0]  debounce_dec;
   logic [4:0]  month_len;
   logic [2:0]  keys_now;

   assign tick_sum     = {1'b0, tick_ff} + 7'd1;
   assign sec_sum      = {1'b0, cal_ff.second} + 7'd1;
   assign min_sum      = {1'b0, cal_ff.minute} + 7'd1;
   assign hour_sum     = {1'b0, cal_ff.hour} + 6'd1;
   assign day_sum      = {1'b0, cal_ff.day} + 6'd1;
   assign month_sum    = {1'b0, cal_ff.month} + 5'd1;
   assign year_sum     = {1'b0, cal_ff.year} + 7'd1;
   assign year_next    = (year_sum >= rtccal_pkg::YEAR_END) ? rtccal_pkg::YEAR_FIRST
                                                           : year_sum[5:0];
   assign debounce_dec = debounce_ff - 5'd1;
   assign month_len    = (cal_ff.month == rtccal_pkg::MONTH_FEB && leap_ff)
                         ? rtccal_pkg::FEB_LEAP_LEN : rtccal_pkg::MONTH_DAYS[cal_ff.month];
   assign keys_now     = ~req_key_pins;

   assign roll.second = (req_func == rtccal_pkg::FUNC_TICK) &&
                        (tick_sum >= 7'(TICKS_PER_SECOND));
   assign roll.minute = roll.second && (sec_sum >= rtccal_pkg::SEC_LIMIT);

   always_comb begin
      tick_in     = tick_ff;
      debounce_in = debounce_ff;
      leap_in     = leap_ff;
      cal_in      = cal_ff;

      if (ctrl.accept) begin
         cal_in.read_flag   = cal_ff.read_flag & ~req_clear_read;
         cal_in.update_flag = cal_ff.update_flag & ~req_clear_update;
         cal_in.key_flag    = cal_ff.key_flag & ~req_clear_key;

         unique case (req_func)
            rtccal_pkg::FUNC_TICK: begin
               debounce_in = debounce_dec;
               if (debounce_dec == 5'd0) begin
                  debounce_in = 5'd1;
                  cal_in.keys = keys_now;
                  if (keys_now != 3'd0) begin
                     cal_in.key_flag    = 1'b1;
                     debounce_in        = 5'(DEBOUNCE_HOLD);
                     cal_in.update_flag = 1'b0;
                  end
               end

               if (tick_ff == 6'(LED_OFF_TICK)) begin
                  cal_in.led = 1'b0;
               end
               tick_in = tick_sum[5:0];

               if (roll.second) begin
                  tick_in       = 6'd0;
                  cal_in.led    = 1'b1;
                  cal_in.second = sec_sum[5:0];
                  if (cal_ff.wait_left != 16'd0) begin
                     cal_in.wait_left = cal_ff.wait_left - 16'd1;
                  end
                  if (roll.minute) begin
                     cal_in.second = 6'd0;
                     cal_in.minute = min_sum[5:0];
                     if (min_sum >= rtccal_pkg::MIN_LIMIT) begin
                        cal_in.minute = 6'd0;
                        cal_in.hour   = hour_sum[4:0];
                        if (hour_sum >= rtccal_pkg::HOUR_LIMIT) begin
                           cal_in.hour = 5'd0;
                           cal_in.day  = day_sum[4:0];
                           if (day_sum > {1'b0, month_len}) begin
                              cal_in.day   = 5'd1;
                              cal_in.month = month_sum[3:0];
                              if (month_sum > rtccal_pkg::MONTH_LAST) begin
                                 // New Year: February's length is settled here only.
                                 cal_in.month = 4'd1;
                                 cal_in.year  = year_next;
                                 leap_in      = (year_next[1:0] == 2'd0);
                              end
                           end
                        end
                     end
                  end
               end
            end
            rtccal_pkg::FUNC_WAIT: begin
               cal_in.wait_left = req_wait_load;
            end
            rtccal_pkg::FUNC_SET: begin
               cal_in.second = req_set_second;
               cal_in.minute = req_set_minute;
               cal_in.hour   = req_set_hour;
               cal_in.day    = req_set_day;
               cal_in.month  = req_set_month;
               cal_in.year   = req_set_year;
            end
            default: begin
            end
         endcase
      end

      if (ctrl.apply_read && !cfg.single_mode && !cfg.no_bus_mode &&
          (rem.zero || cal_ff.minute == 6'd0)) begin
         cal_in.read_flag   = 1'b1;
         cal_in.update_flag = 1'b0;
      end

      if (ctrl.apply_update && !cal_ff.read_flag && cal_ff.wait_left == 16'd0 &&
          rem.zero) begin
         cal_in.update_flag = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff            <= 6'd0;
         debounce_ff        <= 5'd1;
         leap_ff            <= 1'b0;
         cal_ff.second      <= 6'd0;
         cal_ff.minute      <= 6'd4;
         cal_ff.hour        <= 5'd12;
         cal_ff.day         <= 5'd1;
         cal_ff.month       <= 4'd10;
         cal_ff.year        <= 6'd14;
         cal_ff.keys        <= 3'd0;
         cal_ff.key_flag    <= 1'b0;
         cal_ff.read_flag   <= 1'b0;
         cal_ff.update_flag <= 1'b0;
         cal_ff.led         <= 1'b0;
         cal_ff.wait_left   <= 16'd0;
      end else begin
         tick_ff     <= tick_in;
         debounce_ff <= debounce_in;
         leap_ff     <= leap_in;
         cal_ff      <= cal_in;
      end
   end

   assign cal = cal_ff;

endmodule

`default_nettype wire

// ===== design/rtc_calendar_tick.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   function, key pins, timer load, clock set, clears
// rsp_      out        rsp_valid/rsp_stall   calendar, keys, sticky flags, LED, timer
// csr_      in         csr_write             csr_index selects register, csr_wdata
//
// An item that ends a second runs once through the six-step shift-subtract
// remainder unit, for the seconds test, and one that ends a minute runs
// through it twice, first for the minute test and then for the seconds test;
// other items skip it. No new item is taken until the last one is finished.
// Reset is synchronous and active high and restores the power-up calendar.
// One finished result waits in the output register, and the next item is
// accepted meanwhile; its work halts at the final step until rsp_stall falls.

module rtc_calendar_tick #(
   parameter int TICKS_PER_SECOND = 40,
   parameter int DEBOUNCE_HOLD    = 20,
   parameter int LED_OFF_TICK     = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [2:0]  req_key_pins,
   input  wire logic [15:0] req_wait_load,
   input  wire logic [5:0]  req_set_second,
   input  wire logic [5:0]  req_set_minute,
   input  wire logic [4:0]  req_set_hour,
   input  wire logic [4:0]  req_set_day,
   input  wire logic [3:0]  req_set_month,
   input  wire logic [5:0]  req_set_year,
   input  wire logic        req_clear_read,
   input  wire logic        req_clear_update,
   input  wire logic        req_clear_key,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_second_now,
   output logic [5:0]       rsp_minute_now,
   output logic [4:0]       rsp_hour_now,
   output logic [4:0]       rsp_day_now,
   output logic [3:0]       rsp_month_now,
   output logic [5:0]       rsp_year_now,
   output logic [2:0]       rsp_keys_seen,
   output logic             rsp_key_flag,
   output logic             rsp_read_flag,
   output logic             rsp_update_flag,
   output logic             rsp_led_on,
   output logic [15:0]      rsp_wait_left,

   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [5:0]  csr_wdata
);

   rtccal_pkg::cfg_type  cfg_ff, cfg_in;
   rtccal_pkg::ctrl_type ctrl;
   rtccal_pkg::roll_type roll;
   rtccal_pkg::rem_type  rem;
   rtccal_pkg::cal_type  cal;
   rtccal_pkg::cal_type  rsp_cal_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_free;
   logic [5:0]           rem_dividend;
   logic [5:0]           rem_divisor;

   // Configuration registers; writes to an unused index are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            rtccal_pkg::CSR_SAMPLES: cfg_in.samples_per_hour = csr_wdata;
            rtccal_pkg::CSR_SINGLE:  cfg_in.single_mode      = csr_wdata[0];
            rtccal_pkg::CSR_NO_BUS:  cfg_in.no_bus_mode      = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.samples_per_hour <= rtccal_pkg::SAMPLES_RESET;
         cfg_ff.single_mode      <= 1'b0;
         cfg_ff.no_bus_mode      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The output register is free when empty or when its item leaves this cycle.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   rtccal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_free  (rsp_free),
      .roll      (roll),
      .rem       (rem),
      .ctrl      (ctrl)
   );

   // The shared unit tests the minute against the sampling divisor first and
   // then the second against three.
   assign rem_dividend = ctrl.sel_minute ? cal.minute : cal.second;
   assign rem_divisor  = ctrl.sel_minute ? rtccal_pkg::DIV_TABLE[cfg_ff.samples_per_hour]
                                         : rtccal_pkg::SEC_DIVISOR;

   rtccal_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.rem_start),
      .dividend (rem_dividend),
      .divisor  (rem_divisor),
      .status   (rem)
   );

   rtccal_core #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND),
      .DEBOUNCE_HOLD    (DEBOUNCE_HOLD),
      .LED_OFF_TICK     (LED_OFF_TICK)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .cfg              (cfg_ff),
      .rem              (rem),
      .req_func         (req_func),
      .req_key_pins     (req_key_pins),
      .req_wait_load    (req_wait_load),
      .req_set_second   (req_set_second),
      .req_set_minute   (req_set_minute),
      .req_set_hour     (req_set_hour),
      .req_set_day      (req_set_day),
      .req_set_month    (req_set_month),
      .req_set_year     (req_set_year),
      .req_clear_read   (req_clear_read),
      .req_clear_update (req_clear_update),
      .req_clear_key    (req_clear_key),
      .roll             (roll),
      .cal              (cal)
   );

   assign req_stall = !ctrl.idle;

   // Result register: loaded with the state as it stands once the item is done.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctrl.load_rsp) begin
         rsp_cal_ff <= cal;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_second_now  = rsp_cal_ff.second;
   assign rsp_minute_now  = rsp_cal_ff.minute;
   assign rsp_hour_now    = rsp_cal_ff.hour;
   assign rsp_day_now     = rsp_cal_ff.day;
   assign rsp_month_now   = rsp_cal_ff.month;
   assign rsp_year_now    = rsp_cal_ff.year;
   assign rsp_keys_seen   = rsp_cal_ff.keys;
   assign rsp_key_flag    = rsp_cal_ff.key_flag;
   assign rsp_read_flag   = rsp_cal_ff.read_flag;
   assign rsp_update_flag = rsp_cal_ff.update_flag;
   assign rsp_led_on      = rsp_cal_ff.led;
   assign rsp_wait_left   = rsp_cal_ff.wait_left;

endmodule

`default_nettype wire

// ===== design/rtccal_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtccal_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [5:0]  rsp_second_now,
   input wire logic [5:0]  rsp_minute_now,
   input wire logic [15:0] rsp_wait_left
);

   // After reset no result is shown.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   // An accepted item is not finished when it is taken, so input is held off after it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted in consecutive cycles");

   // A new result appears only at the end of work on an item.
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while no item was in work");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_second_now) &&
                                    $stable(rsp_minute_now) && $stable(rsp_wait_left)))
      else $error("stalled result changed");

endmodule

bind rtc_calendar_tick rtccal_checker u_rtccal_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_second_now (rsp_second_now),
   .rsp_minute_now (rsp_minute_now),
   .rsp_wait_left  (rsp_wait_left)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the tick-driven clock and calendar.
//
// Every accepted item is run through a predictor kept in this module, and the
// calendar snapshot it yields is queued. Each result the block hands over is
// taken against the oldest queued snapshot, field by field.
//
// The stimulus sets the clock just short of a boundary (second, minute,
// hour, month end, New Year, February in a leap or common year, out-of-range
// values) and then ticks across it. Key presses, flag clears, wait timer
// loads and unconstrained items are mixed in. The run steps through
// several idling phases, several register settings and one long hold-off on
// the result side.
module tb_top;

   // Function three has no name in the package; only its flag clears act.
   localparam logic [1:0] FUNC_IDLE = 2'd3;

   localparam int TICKS_PER_SEC   = 40;
   localparam int DEBOUNCE_TICKS  = 20;
   localparam int LED_LAST_TICK   = 5;
   localparam int CYCLE_LIMIT     = 600000;
   // The margin is sized for the slowest item, one that ends a minute.
   localparam int SETTLE_CYCLES   = 24;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct {
      logic [1:0]  func;
      logic [2:0]  key_pins;
      logic [15:0] wait_load;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [5:0]  year;
      logic        clear_read;
      logic        clear_update;
      logic        clear_key;
   } rtc_item_type;

   // Clock, reset and every input of the block hold a known value from the
   // very start of the run.
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = rtccal_pkg::FUNC_TICK;
   logic [2:0]  req_key_pins = 3'b111;
   logic [15:0] req_wait_load = '0;
   logic [5:0]  req_set_second = '0;
   logic [5:0]  req_set_minute = '0;
   logic [4:0]  req_set_hour = '0;
   logic [4:0]  req_set_day = 5'd1;
   logic [3:0]  req_set_month = 4'd1;
   logic [5:0]  req_set_year = 6'd11;
   logic        req_clear_read = 1'b0;
   logic        req_clear_update = 1'b0;
   logic        req_clear_key = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_second_now;
   logic [5:0]  rsp_minute_now;
   logic [4:0]  rsp_hour_now;
   logic [4:0]  rsp_day_now;
   logic [3:0]  rsp_month_now;
   logic [5:0]  rsp_year_now;
   logic [2:0]  rsp_keys_seen;
   logic        rsp_key_flag;
   logic        rsp_read_flag;
   logic        rsp_update_flag;
   logic        rsp_led_on;
   logic [15:0] rsp_wait_left;

   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = rtccal_pkg::CSR_SAMPLES;
   logic [5:0]  csr_wdata = '0;

   rtc_calendar_tick u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predicted state of the block, at the block's own widths.
   logic [5:0]  tick_phase;
   logic [4:0]  hold_count;
   logic [2:0]  pins_latched;
   logic        key_sticky;
   logic        read_sticky;
   logic        update_sticky;
   logic        led_lit;
   logic [15:0] wait_secs;
   logic [5:0]  sec_q;
   logic [5:0]  min_q;
   logic [4:0]  hour_q;
   logic [4:0]  day_q;
   logic [3:0]  month_q;
   logic [5:0]  year_q;
   logic        feb_long;

   // Predicted register contents.
   logic [5:0]  cfg_samples;
   logic        cfg_single;
   logic        cfg_no_bus;

   rtccal_pkg::cal_type calendar_due[$];
   rtccal_pkg::cal_type oldest_due;
   int          fail_count = 0;
   int          items_sent = 0;
   int          cycle_count = 0;

   // Idling controls for the sender and the receiver.
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;

   function automatic void reset_calendar();
      cfg_samples   = rtccal_pkg::SAMPLES_RESET;
      cfg_single    = 1'b0;
      cfg_no_bus    = 1'b0;
      tick_phase    = '0;
      hold_count    = 5'd1;
      pins_latched  = '0;
      key_sticky    = 1'b0;
      read_sticky   = 1'b0;
      update_sticky = 1'b0;
      led_lit       = 1'b0;
      wait_secs     = '0;
      sec_q         = 6'd0;
      min_q         = 6'd4;
      hour_q        = 5'd12;
      day_q         = 5'd1;
      month_q       = 4'd10;
      year_q        = 6'd14;
      feb_long      = 1'b0;
   endfunction

   // Month zero has no days at all; codes above twelve count as 31.
   function automatic int month_length(input logic [3:0] month, input logic leap);
      case (month)
         4'd0: return 0;
         4'd2: return leap ? 29 : 28;
         4'd4, 4'd6, 4'd9, 4'd11: return 30;
         default: return 31;
      endcase
   endfunction

   // A day rollover; the February length is only worked out at New Year.
   function automatic void roll_day();
      if (int'(day_q) + 1 > month_length(month_q, feb_long)) begin
         day_q = 5'd1;
         if (int'(month_q) + 1 > 12) begin
            month_q = 4'd1;
            if (int'(year_q) + 1 >= 50) begin
               year_q = 6'd11;
            end else begin
               year_q = year_q + 6'd1;
            end
            feb_long = (year_q % 4) == 0;
         end else begin
            month_q = month_q + 4'd1;
         end
      end else begin
         day_q = day_q + 5'd1;
      end
   endfunction

   function automatic void advance_tick(input logic [2:0] pins);
      int divisor;
      // Keys are only looked at once the debounce count runs out, and a
      // press holds further sampling off.
      hold_count = hold_count - 5'd1;
      if (hold_count == 5'd0) begin
         hold_count   = 5'd1;
         pins_latched = ~pins;
         if (pins_latched != 3'd0) begin
            key_sticky    = 1'b1;
            hold_count    = 5'(DEBOUNCE_TICKS);
            update_sticky = 1'b0;
         end
      end

      if (tick_phase == LED_LAST_TICK) begin
         led_lit = 1'b0;
      end
      // Counters are stepped in wide arithmetic so that an out-of-range
      // value that was set still reaches its limit.
      if (int'(tick_phase) + 1 >= TICKS_PER_SEC) begin
         tick_phase = '0;
         led_lit    = 1'b1;
         if (wait_secs != 16'd0) begin
            wait_secs = wait_secs - 16'd1;
         end
         if (int'(sec_q) + 1 >= 60) begin
            sec_q = '0;
            if (int'(min_q) + 1 >= 60) begin
               min_q = '0;
               if (int'(hour_q) + 1 >= 24) begin
                  hour_q = '0;
                  roll_day();
               end else begin
                  hour_q = hour_q + 5'd1;
               end
            end else begin
               min_q = min_q + 6'd1;
            end
            if (cfg_samples == 6'd0) begin
               divisor = 60;
            end else if (cfg_samples > 6'd60) begin
               divisor = 1;
            end else begin
               divisor = 60 / int'(cfg_samples);
            end
            if (!cfg_single && !cfg_no_bus &&
                ((int'(min_q) % divisor) == 0 || min_q == 6'd0)) begin
               read_sticky   = 1'b1;
               update_sticky = 1'b0;
            end
         end else begin
            sec_q = sec_q + 6'd1;
         end
         if (!read_sticky && wait_secs == 16'd0 && (int'(sec_q) % 3) == 0) begin
            update_sticky = 1'b1;
         end
      end else begin
         tick_phase = tick_phase + 6'd1;
      end
   endfunction

   // Applies one item to the predicted state and returns the snapshot that
   // the block should report for it.
   function automatic rtccal_pkg::cal_type apply_item(input rtc_item_type it);
      rtccal_pkg::cal_type snap;
      if (it.clear_read) begin
         read_sticky = 1'b0;
      end
      if (it.clear_update) begin
         update_sticky = 1'b0;
      end
      if (it.clear_key) begin
         key_sticky = 1'b0;
      end
      case (it.func)
         rtccal_pkg::FUNC_TICK: advance_tick(it.key_pins);
         rtccal_pkg::FUNC_WAIT: wait_secs = it.wait_load;
         rtccal_pkg::FUNC_SET: begin
            // Setting the clock leaves the tick phase and February alone.
            sec_q   = it.second;
            min_q   = it.minute;
            hour_q  = it.hour;
            day_q   = it.day;
            month_q = it.month;
            year_q  = it.year;
         end
         default: ;
      endcase
      snap.second      = sec_q;
      snap.minute      = min_q;
      snap.hour        = hour_q;
      snap.day         = day_q;
      snap.month       = month_q;
      snap.year        = year_q;
      snap.keys        = pins_latched;
      snap.key_flag    = key_sticky;
      snap.read_flag   = read_sticky;
      snap.update_flag = update_sticky;
      snap.led         = led_lit;
      snap.wait_left   = wait_secs;
      return snap;
   endfunction

   function automatic rtc_item_type random_item();
      rtc_item_type it;
      it.func         = $urandom_range(0, 3);
      it.key_pins     = $urandom_range(0, 7);
      it.wait_load    = $urandom_range(0, 65535);
      it.second       = $urandom_range(0, 63);
      it.minute       = $urandom_range(0, 63);
      it.hour         = $urandom_range(0, 31);
      it.day          = $urandom_range(0, 31);
      it.month        = $urandom_range(0, 15);
      it.year         = $urandom_range(0, 63);
      it.clear_read   = $urandom_range(0, 1);
      it.clear_update = $urandom_range(0, 1);
      it.clear_key    = $urandom_range(0, 1);
      return it;
   endfunction

   // An item of the given function; unused fields carry random bits, which
   // the block must ignore, and no flag is cleared.
   function automatic rtc_item_type blank_item(input logic [1:0] func);
      rtc_item_type it;
      it              = random_item();
      it.func         = func;
      it.clear_read   = 1'b0;
      it.clear_update = 1'b0;
      it.clear_key    = 1'b0;
      return it;
   endfunction

   function automatic rtc_item_type set_item(input logic [5:0] second, input logic [5:0] minute,
                                             input logic [4:0] hour, input logic [4:0] day,
                                             input logic [3:0] month, input logic [5:0] year);
      rtc_item_type it;
      it        = blank_item(rtccal_pkg::FUNC_SET);
      it.second = second;
      it.minute = minute;
      it.hour   = hour;
      it.day    = day;
      it.month  = month;
      it.year   = year;
      return it;
   endfunction

   function automatic rtc_item_type wait_item(input logic [15:0] seconds);
      rtc_item_type it;
      it           = blank_item(rtccal_pkg::FUNC_WAIT);
      it.wait_load = seconds;
      return it;
   endfunction

   function automatic rtc_item_type clear_item(input logic clr_read, input logic clr_update,
                                               input logic clr_key);
      rtc_item_type it;
      it              = blank_item(FUNC_IDLE);
      it.clear_read   = clr_read;
      it.clear_update = clr_update;
      it.clear_key    = clr_key;
      return it;
   endfunction

   function automatic rtc_item_type tick_item(input logic [2:0] pins);
      rtc_item_type it;
      it          = blank_item(rtccal_pkg::FUNC_TICK);
      it.key_pins = pins;
      return it;
   endfunction

   // Offers one item, after a random idle gap, and waits until it is taken.
   // The handshake is looked at right after the edge, before any register
   // has moved, so the values seen are those the block sampled.
   task automatic send_item(input rtc_item_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= it.func;
      req_key_pins     <= it.key_pins;
      req_wait_load    <= it.wait_load;
      req_set_second   <= it.second;
      req_set_minute   <= it.minute;
      req_set_hour     <= it.hour;
      req_set_day      <= it.day;
      req_set_month    <= it.month;
      req_set_year     <= it.year;
      req_clear_read   <= it.clear_read;
      req_clear_update <= it.clear_update;
      req_clear_key    <= it.clear_key;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      calendar_due.push_back(apply_item(it));
      items_sent++;
   endtask

   // Lets the block run dry: no item offered, every result back, and then
   // a margin that covers the slowest item on top.
   task automatic settle();
      req_valid <= 1'b0;
      while (calendar_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The enable is left high here so that back-to-back writes never lower
   // and raise it in the same step; the caller lowers it after the last one.
   task automatic write_csr(input logic [1:0] index, input logic [5:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         rtccal_pkg::CSR_SAMPLES: cfg_samples = value;
         rtccal_pkg::CSR_SINGLE:  cfg_single  = value[0];
         rtccal_pkg::CSR_NO_BUS:  cfg_no_bus  = value[0];
         default: ;
      endcase
   endtask

   // The mode registers get random upper bits, which must be ignored.
   task automatic apply_config(input logic [5:0] samples, input logic single,
                               input logic no_bus);
      settle();
      write_csr(rtccal_pkg::CSR_SAMPLES, samples);
      write_csr(rtccal_pkg::CSR_SINGLE, {5'($urandom), single});
      write_csr(rtccal_pkg::CSR_NO_BUS, {5'($urandom), no_bus});
      csr_write <= 1'b0;
   endtask

   // Ticks with mostly released keys, now and then a press, a flag clear or
   // an unconstrained item thrown in.
   task automatic run_ticks(input int count);
      rtc_item_type it;
      repeat (count) begin
         if ($urandom_range(0, 99) < 3) begin
            it = random_item();
         end else begin
            it = tick_item(3'b111);
            if ($urandom_range(0, 99) < 12) begin
               it.key_pins = $urandom_range(0, 7);
            end
            it.clear_read   = ($urandom_range(0, 99) < 4);
            it.clear_update = ($urandom_range(0, 99) < 4);
            it.clear_key    = ($urandom_range(0, 99) < 4);
         end
         send_item(it);
      end
   endtask

   // One well-formed sequence: set the clock near a boundary and tick across
   // it. A few sequences are plain bursts of unconstrained items.
   task automatic run_calendar_sequence();
      rtc_item_type it;
      int kind;
      kind = $urandom_range(0, 9);
      if (kind >= 8) begin
         repeat ($urandom_range(3, 12)) send_item(random_item());
      end else if (kind == 6) begin
         // Into a new year, then across the end of its February, which is
         // 29 days long only when the new year is a multiple of four.
         send_item(set_item(59, 59, 23, 31, 12, $urandom_range(11, 48)));
         run_ticks(41);
         send_item(set_item(59, 59, 23, 28, 2, year_q));
         run_ticks(41);
         send_item(set_item(59, 59, 23, 29, 2, year_q));
         run_ticks(41);
      end else begin
         it = set_item($urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 23),
                       $urandom_range(1, 28), $urandom_range(1, 12), $urandom_range(11, 49));
         case (kind)
            1: it.second = $urandom_range(57, 59);
            2: begin
               it.second = 59;
               it.minute = 59;
            end
            3: begin
               // End of a month, at times a day past the end of a short one.
               it.second = 59;
               it.minute = 59;
               it.hour   = 23;
               it.day    = $urandom_range(month_length(it.month, feb_long), 31);
            end
            4: begin
               it.second = 59;
               it.minute = 59;
               it.hour   = 23;
               it.day    = 31;
               it.month  = 12;
               if ($urandom_range(0, 3) == 0) begin
                  it.year = 49;
               end
            end
            5: begin
               // Out-of-range values and months with no days or too many.
               it.second = $urandom_range(56, 63);
               it.minute = $urandom_range(58, 63);
               it.hour   = $urandom_range(22, 31);
               it.day    = $urandom_range(0, 31);
               it.month  = $urandom_range(0, 15);
               it.year   = $urandom_range(0, 63);
            end
            default: ;
         endcase
         send_item(it);
         if (kind == 7) begin
            // A short wait, so update requests can follow once it runs out.
            send_item(wait_item($urandom_range(1, 4)));
            run_ticks($urandom_range(130, 200));
         end else begin
            if ($urandom_range(0, 9) < 4) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_item(wait_item($urandom_range(0, 65535)));
               end else begin
                  send_item(wait_item($urandom_range(0, 3)));
               end
            end
            run_ticks(kind == 0 ? $urandom_range(40, 130) : $urandom_range(40, 60));
         end
      end
   endtask

   // Field extremes, every function and the key and clear cases, straight
   // after reset.
   task automatic test_directed_extremes();
      send_item(clear_item(1'b1, 1'b1, 1'b1));
      send_item(tick_item(3'b111));
      // All keys down: the press is latched and sampling is held off.
      send_item(tick_item(3'b000));
      send_item(tick_item(3'b110));
      send_item(clear_item(1'b0, 1'b0, 1'b1));
      send_item(wait_item(16'hFFFF));
      send_item(tick_item(3'b101));
      send_item(wait_item(16'h0000));
      send_item(wait_item(16'h0001));
      send_item(set_item(6'h3F, 6'h3F, 5'h1F, 5'h1F, 4'hF, 6'h3F));
      send_item(tick_item(3'b011));
      send_item(set_item(0, 0, 0, 0, 0, 0));
      send_item(tick_item(3'b111));
      send_item(set_item(59, 59, 23, 31, 12, 49));
      send_item(tick_item(3'b111));
      send_item(set_item(0, 0, 0, 1, 1, 11));
      send_item(clear_item(1'b1, 1'b0, 1'b0));
      send_item(clear_item(1'b0, 1'b1, 1'b0));
      send_item(random_item());
      send_item(tick_item(3'b111));
      send_item(tick_item(3'b010));
      send_item(clear_item(1'b1, 1'b1, 1'b1));
   endtask

   // One minute boundary under each of several read rates and modes, the extreme
   // rates and both suppressing modes among them.
   task automatic test_read_rate_settings();
      for (int n = 0; n < 9; n++) begin
         case (n)
            0: apply_config(rtccal_pkg::SAMPLES_RESET, 1'b0, 1'b0);
            1: apply_config(6'd0, 1'b0, 1'b0);
            2: apply_config(6'd1, 1'b0, 1'b0);
            3: apply_config(6'd60, 1'b0, 1'b0);
            4: apply_config(6'd63, 1'b0, 1'b0);
            5: apply_config(rtccal_pkg::SAMPLES_RESET, 1'b1, 1'b0);
            6: apply_config(rtccal_pkg::SAMPLES_RESET, 1'b0, 1'b1);
            7: apply_config(6'd5, 1'b1, 1'b1);
            default: apply_config($urandom_range(1, 59), 1'b0, 1'b0);
         endcase
         send_item(set_item(59, $urandom_range(0, 59), $urandom_range(0, 23),
                            $urandom_range(1, 28), $urandom_range(1, 12),
                            $urandom_range(11, 49)));
         run_ticks(45);
      end
   endtask

   // Random sequences under one idling pattern and a random setting.
   task automatic test_idle_phase(input int sender_pct, input int receiver_pct,
                                  input int count);
      int first;
      apply_config($urandom_range(0, 63), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 3) == 0);
      send_idle_pct = sender_pct;
      stall_pct     = receiver_pct;
      first         = items_sent;
      while (items_sent - first < count) begin
         run_calendar_sequence();
      end
   endtask

   // The result side holds off for a long stretch while items keep coming,
   // so the block fills up and has to stall its input.
   task automatic test_output_hold_off();
      apply_config(rtccal_pkg::SAMPLES_RESET, 1'b0, 1'b0);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = 1'b1;
      run_ticks(60);
   endtask

   // Result side stall. A hold-off request is counted down here, cycle by
   // cycle; otherwise the stall follows the current idling pattern.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_OFF_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [15:0] due,
                              input logic [15:0] seen);
      if (seen !== due) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, due, seen);
         fail_count++;
      end
   endtask

   // Every result taken at an edge is held against the oldest snapshot due.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (calendar_due.size() == 0) begin
            $display("%0t ns: result taken with none expected, expected none, got second %0d",
                     $time, rsp_second_now);
            fail_count++;
         end else begin
            oldest_due = calendar_due.pop_front();
            check_field("second_now", oldest_due.second, rsp_second_now);
            check_field("minute_now", oldest_due.minute, rsp_minute_now);
            check_field("hour_now", oldest_due.hour, rsp_hour_now);
            check_field("day_now", oldest_due.day, rsp_day_now);
            check_field("month_now", oldest_due.month, rsp_month_now);
            check_field("year_now", oldest_due.year, rsp_year_now);
            check_field("keys_seen", oldest_due.keys, rsp_keys_seen);
            check_field("key_flag", oldest_due.key_flag, rsp_key_flag);
            check_field("read_flag", oldest_due.read_flag, rsp_read_flag);
            check_field("update_flag", oldest_due.update_flag, rsp_update_flag);
            check_field("led_on", oldest_due.led, rsp_led_on);
            check_field("wait_left", oldest_due.wait_left, rsp_wait_left);
         end
      end
   end

   // Guard against a hang: a result that never comes ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset_calendar();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_read_rate_settings();
      test_idle_phase(0, 0, 200);
      test_idle_phase(52, 0, 200);
      test_idle_phase(0, 52, 200);
      test_idle_phase(23, 23, 200);
      test_output_hold_off();

      settle();
      if (fail_count == 0 && calendar_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== rtc_calendar_tick.f =====
design/rtccal_pkg.sv
design/rtccal_rem.sv
design/rtccal_ctrl.sv
design/rtccal_core.sv
design/rtc_calendar_tick.sv
design/rtccal_checker.sv
dv/tb_top.sv
